@@ hdl/fixed_time_signal_state_query_unit_defines.svh @@
// Assertion macros for the fixed-time signal state query unit
`ifndef FIXED_TIME_SIGNAL_STATE_QUERY_UNIT_DEFINES_SVH
`define FIXED_TIME_SIGNAL_STATE_QUERY_UNIT_DEFINES_SVH

// implication checked every clock, quiet in reset
`define FTSQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define FTSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hdl/ftsq_pkg.sv @@
// Package: types and constants of the fixed-time signal state query unit
package ftsq_pkg;

	localparam int unsigned TW = 16;
	localparam int unsigned CW = 24;
	localparam int unsigned QW = 32;
	// width of a time value during the walk (cycle plus a phase plus margin)
	localparam int unsigned WW = 34;

	localparam logic [CW-1:0] MIN_CYCLE = CW'(10);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] REG_OFFSET = 2'd0;
	localparam logic [1:0] REG_CYCLE  = 2'd1;
	localparam logic [1:0] REG_COUNT  = 2'd2;

	localparam logic [1:0] VEH_OFF = 2'd0;
	localparam logic [1:0] VEH_RED = 2'd1;
	localparam logic [1:0] VEH_YEL = 2'd2;
	localparam logic [1:0] VEH_GRN = 2'd3;

	localparam logic [1:0] PED_OFF   = 2'd0;
	localparam logic [1:0] PED_DONT  = 2'd1;
	localparam logic [1:0] PED_FLASH = 2'd2;
	localparam logic [1:0] PED_WALK  = 2'd3;

	typedef struct packed {
		logic          operation;
		logic [4:0]    phase_slot;
		logic [7:0]    group_id;
		logic [TW-1:0] lead_interval;
		logic [TW-1:0] green_time;
		logic [TW-1:0] yellow_time;
		logic [TW-1:0] all_red_time;
		logic [TW-1:0] walk_time;
		logic [TW-1:0] flash_time;
		logic [QW-1:0] query_time;
	} in_item_t;

	typedef struct packed {
		logic [1:0]    vehicle_aspect;
		logic [1:0]    pedestrian_aspect;
		logic [CW-1:0] wait_to_green;
		logic [CW-1:0] green_left;
		logic [CW-1:0] red_time;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MOD,
		ST_WALK,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // take input item
		logic load;      // write phase into table
		logic sum_clr;
		logic sum_step;  // add one phase length
		logic mod_init;
		logic mod_step;  // one restoring division bit
		logic walk_clr;
		logic walk_step; // evaluate one phase
		logic finish;    // build result
		logic zero_res;  // result of a load item
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic is_query;
		logic idx_last;  // last phase of the table visited
		logic mod_last;  // last division bit
		logic empty;     // no phase in use
	} sts_t;

endpackage

@@ hdl/ftsq_ctrl.sv @@
// Controller: sequences load, sum, modulo and phase walk
module ftsq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  ftsq_pkg::sts_t    sts,
	output ftsq_pkg::ctl_t    ctl
);
	ftsq_pkg::state_t state_q, state_nxt;
	logic out_valid_q;
	logic acc;

	assign acc = in_valid && !in_stall;
	assign in_stall = (state_q != ftsq_pkg::ST_IDLE) || (out_valid_q && out_stall);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ftsq_pkg::ST_IDLE: begin
				if (acc) state_nxt = ftsq_pkg::ST_SUM;
			end
			ftsq_pkg::ST_SUM: begin
				if (!sts.is_query) state_nxt = ftsq_pkg::ST_DONE;
				else if (sts.empty || sts.idx_last) state_nxt = ftsq_pkg::ST_MOD;
			end
			ftsq_pkg::ST_MOD: begin
				if (sts.mod_last) state_nxt = sts.empty ? ftsq_pkg::ST_DONE : ftsq_pkg::ST_WALK;
			end
			ftsq_pkg::ST_WALK: begin
				if (sts.idx_last) state_nxt = ftsq_pkg::ST_DONE;
			end
			ftsq_pkg::ST_DONE: state_nxt = ftsq_pkg::ST_IDLE;
			default: state_nxt = ftsq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.capture = acc;
		ctl.sum_clr = acc;
		unique case (state_q)
			ftsq_pkg::ST_IDLE: ;
			ftsq_pkg::ST_SUM: begin
				if (!sts.is_query) ctl.load = 1'b1;
				else begin
					ctl.sum_step = !sts.empty;
					ctl.mod_init = sts.empty || sts.idx_last;
				end
			end
			ftsq_pkg::ST_MOD: begin
				ctl.mod_step = 1'b1;
				ctl.walk_clr = sts.mod_last;
			end
			ftsq_pkg::ST_WALK: ctl.walk_step = 1'b1;
			ftsq_pkg::ST_DONE: begin
				ctl.finish = sts.is_query;
				ctl.zero_res = !sts.is_query;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ftsq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ftsq_pkg::ST_DONE) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end
endmodule

@@ hdl/ftsq_datapath.sv @@
// Datapath: phase table, cycle sum, modulo divider and phase walk
module ftsq_datapath #(
	parameter int unsigned MAX_PHASES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [23:0]         cfg_data,
	input  ftsq_pkg::in_item_t  in_item,
	input  ftsq_pkg::ctl_t      ctl,
	output ftsq_pkg::sts_t      sts,
	output ftsq_pkg::out_item_t out_item
);
	localparam int unsigned AW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
	localparam int unsigned WW = ftsq_pkg::WW;
	localparam int unsigned CW = ftsq_pkg::CW;
	localparam int unsigned TW = ftsq_pkg::TW;
	localparam int unsigned RW = 33;  // signed reduced time
	localparam logic [6:0] MAXP = 7'(MAX_PHASES > 64 ? 64 : MAX_PHASES);

	// phase memory: group, lead, green, yellow, all-red, walk, flash
	localparam int unsigned EW = 8 + 6 * TW;
	logic [EW-1:0] mem [MAX_PHASES];
	logic [EW-1:0] rd_q;

	logic [TW-1:0] offset_q;
	logic [CW-1:0] decl_q;
	logic [5:0]    count_q;
	ftsq_pkg::in_item_t item_q;
	logic [AW:0]   idx_q;
	logic [6:0]    n;
	logic          rd_ok_q;
	logic [WW-1:0] total_q, cycle_q, start_q, go_q;
	logic [RW:0]   rem_q;      // partial remainder
	logic [RW-1:0] dvd_q;      // magnitude of dividend, shifted out
	logic          neg_q;
	logic [5:0]    bit_q;
	logic [WW-1:0] tc_q;
	logic [1:0]    veh_q, ped_q;
	logic          found_q, ing_q, wvalid_q;
	logic [WW-1:0] grem_q, wait_q;
	ftsq_pkg::out_item_t res_q;

	// clipping on load
	logic [17:0] lim, wf;
	logic [TW-1:0] w_clip, f_clip;
	always_comb begin
		wf  = 18'(item_q.walk_time) + 18'(item_q.flash_time);
		lim = 18'(item_q.lead_interval) + 18'(item_q.green_time) + 18'(item_q.yellow_time);
		f_clip = item_q.flash_time;
		w_clip = item_q.walk_time;
		if (wf > lim) begin
			if (18'(item_q.flash_time) > lim) f_clip = TW'(lim);
			w_clip = TW'(lim - 18'(f_clip));
		end
	end

	assign n = (7'(count_q) > MAXP) ? MAXP : 7'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			decl_q   <= '0;
			count_q  <= '0;
		end else if (cfg_write) begin
			priority if (cfg_index == ftsq_pkg::REG_OFFSET) offset_q <= cfg_data[TW-1:0];
			else if (cfg_index == ftsq_pkg::REG_CYCLE) decl_q <= cfg_data;
			else if (cfg_index == ftsq_pkg::REG_COUNT) count_q <= cfg_data[5:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && ({1'b0, item_q.phase_slot} < 6'(MAX_PHASES > 32 ? 32 : MAX_PHASES)))
			mem[AW'(item_q.phase_slot)] <= {item_q.group_id, item_q.lead_interval,
				item_q.green_time, item_q.yellow_time, item_q.all_red_time, w_clip, f_clip};
		rd_q <= mem[idx_q[AW-1:0]];
	end

	// fields of the registered entry
	logic [7:0]    e_grp;
	logic [TW-1:0] e_lead, e_grn, e_yel, e_ar, e_walk, e_fl;
	assign {e_grp, e_lead, e_grn, e_yel, e_ar, e_walk, e_fl} = rd_q;
	logic [WW-1:0] e_len;
	assign e_len = WW'(e_lead) + WW'(e_grn) + WW'(e_yel) + WW'(e_ar);

	// divider
	logic [RW-1:0] rel_mag;
	logic          rel_neg;
	logic [RW:0]   trial;
	logic signed [RW:0] rel_s;
	assign rel_s   = $signed({2'b00, item_q.query_time}) - $signed({18'd0, offset_q});
	assign rel_neg = rel_s[RW];
	assign rel_mag = rel_neg ? RW'(-rel_s) : RW'(rel_s);
	assign trial   = {rem_q[RW-1:0], dvd_q[RW-1]} - (RW+1)'(cycle_q);

	// walk evaluation
	logic [WW-1:0] local_t, gs, ge, d, a_lead, a_ge, a_ye, a_w, a_f;
	logic          lneg, hit;
	logic [1:0]    v, p;
	always_comb begin
		local_t = tc_q - start_q;
		lneg    = tc_q < start_q;
		a_lead  = WW'(e_lead);
		a_ge    = a_lead + WW'(e_grn);
		a_ye    = a_ge + WW'(e_yel);
		a_w     = WW'(e_walk);
		a_f     = a_w + WW'(e_fl);
		v = ftsq_pkg::VEH_RED;
		if (!lneg && local_t >= a_lead && local_t < a_ge) v = ftsq_pkg::VEH_GRN;
		else if (!lneg && local_t >= a_ge && local_t < a_ye) v = ftsq_pkg::VEH_YEL;
		p = ftsq_pkg::PED_DONT;
		if (!lneg && local_t < a_w) p = ftsq_pkg::PED_WALK;
		else if (!lneg && local_t < a_f) p = ftsq_pkg::PED_FLASH;
		gs = start_q + a_lead;
		ge = gs + WW'(e_grn);
		d  = (gs >= tc_q) ? gs - tc_q : gs + cycle_q - tc_q;
		hit = rd_ok_q && (e_grp == item_q.group_id);
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) item_q <= in_item;
		if (ctl.sum_clr) begin
			idx_q <= '0; total_q <= '0; rd_ok_q <= 1'b0;
		end
		if (ctl.sum_step) begin
			// entry idx-1 is in rd_q when rd_ok_q
			if (rd_ok_q) total_q <= total_q + e_len;
			if (idx_q != (AW+1)'(n)) idx_q <= idx_q + 1'b1;
			rd_ok_q <= (idx_q != (AW+1)'(n));
		end
		if (ctl.mod_init) begin
			logic [WW-1:0] t;
			t = total_q + ((rd_ok_q && ctl.sum_step) ? e_len : '0);
			if (t == '0) t = WW'(ftsq_pkg::MIN_CYCLE);
			cycle_q <= (WW'(decl_q) > t) ? WW'(decl_q) : t;
			rem_q <= '0; dvd_q <= rel_mag; neg_q <= rel_neg;
			bit_q <= 6'(RW - 1);
		end
		if (ctl.mod_step) begin
			if (!trial[RW]) rem_q <= trial;
			else rem_q <= {rem_q[RW-1:0], dvd_q[RW-1]};
			dvd_q <= dvd_q << 1;
			bit_q <= bit_q - 1'b1;
		end
		if (ctl.walk_clr) begin
			logic [WW-1:0] r;
			r = WW'(!trial[RW] ? trial : {rem_q[RW-1:0], dvd_q[RW-1]});
			tc_q <= (neg_q && r != '0) ? cycle_q - r : r;
			idx_q <= '0; rd_ok_q <= 1'b0; start_q <= '0; go_q <= '0;
			veh_q <= ftsq_pkg::VEH_OFF; ped_q <= ftsq_pkg::PED_OFF;
			found_q <= 1'b0; ing_q <= 1'b0; wvalid_q <= 1'b0;
			grem_q <= '0; wait_q <= '0;
		end
		if (ctl.walk_step) begin
			if (idx_q != (AW+1)'(n)) idx_q <= idx_q + 1'b1;
			rd_ok_q <= (idx_q != (AW+1)'(n));
			if (rd_ok_q) begin
				start_q <= start_q + e_len;
				if (hit) begin
					found_q <= 1'b1;
					if (v > veh_q) veh_q <= v;
					if (p > ped_q) ped_q <= p;
					if (tc_q >= gs && tc_q < ge) begin
						if (!ing_q) grem_q <= ge - tc_q;
						ing_q <= 1'b1;
					end
					if (!wvalid_q || d < wait_q) wait_q <= d;
					wvalid_q <= 1'b1;
					go_q <= go_q + WW'(e_grn) + WW'(e_yel);
				end
			end
		end
		if (ctl.zero_res) res_q <= '0;
		if (ctl.finish) begin
			if (!found_q) res_q <= '0;
			else begin
				res_q.vehicle_aspect    <= veh_q;
				res_q.pedestrian_aspect <= ped_q;
				res_q.wait_to_green     <= ing_q ? '0 : CW'(wait_q);
				res_q.green_left        <= ing_q ? CW'(grem_q) : '0;
				res_q.red_time          <= (cycle_q > go_q) ? CW'(cycle_q - go_q) : '0;
			end
		end
	end

	// walk ends when the last entry has been read into rd_q
	assign sts.is_query = item_q.operation == ftsq_pkg::OP_QUERY;
	assign sts.empty    = n == 7'd0;
	assign sts.idx_last = rd_ok_q && (idx_q == (AW+1)'(n));
	assign sts.mod_last = bit_q == 6'd0;
	assign out_item = res_q;
endmodule

@@ hdl/fixed_time_signal_state_query_unit.sv @@
// Top level of the fixed-time signal state query unit
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | ftsq_pkg::in_item_t
//  out     | output    | out_valid / out_stall| ftsq_pkg::out_item_t
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
// A load item: the table is written, then the all-zero result is formed and made valid.
// A query with n phases in use: a pass over the table for the cycle sum, a bitwise modulo
// of (time - offset) by the cycle, a second pass for the phase walk, then the result is
// formed and made valid. With no phase in use the phase walk is skipped.
// Reset clears control and configuration; the phase table is not cleared.
// One item at a time: in_stall is high while an item is at work or the result is held.
module fixed_time_signal_state_query_unit #(
	parameter int unsigned MAX_PHASES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ftsq_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output ftsq_pkg::out_item_t out_item,
	input  logic                cfg_write,
	input  logic [1:0]          cfg_index,
	input  logic [23:0]         cfg_data
);
	ftsq_pkg::ctl_t ctl;
	ftsq_pkg::sts_t sts;

	ftsq_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .ctl
	);

	ftsq_datapath #(.MAX_PHASES(MAX_PHASES)) u_dp (
		.clk, .arst_n, .cfg_write, .cfg_index, .cfg_data, .in_item, .ctl, .sts, .out_item
	);
endmodule

@@ hdl/ftsq_checker.sv @@
// Port checker for the fixed-time signal state query unit
`include "fixed_time_signal_state_query_unit_defines.svh"
module ftsq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input ftsq_pkg::out_item_t out_item
);
	`FTSQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item))
	`FTSQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	`FTSQ_ASSERT_IMPL(a_no_take_while_full, clk, arst_n, out_valid && out_stall, in_stall)
	`FTSQ_ASSERT_NEXT(a_no_early_result, clk, arst_n, in_valid && !in_stall, !out_valid || out_stall)
endmodule

bind fixed_time_signal_state_query_unit ftsq_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_item
);

@@ dv/fixed_time_signal_state_query_unit_tb.sv @@
// Testbench for the fixed-time signal state query unit: directed table, random plans, scoreboard
`timescale 1ns / 1ps

module fixed_time_signal_state_query_unit_tb;
	import ftsq_pkg::*;

	localparam int unsigned TABLE_DEPTH = 32;
	localparam int unsigned CYCLE_LIMIT = 900000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_item;
	logic        cfg_write;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	fixed_time_signal_state_query_unit #(
		.MAX_PHASES(TABLE_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Own copy of the plan: configuration and the phase table
	logic [15:0] plan_ofs;
	logic [23:0] plan_cycle_decl;
	logic [5:0]  plan_phases;
	logic [7:0]  tbl_group [TABLE_DEPTH];
	logic [15:0] tbl_lead  [TABLE_DEPTH];
	logic [15:0] tbl_green [TABLE_DEPTH];
	logic [15:0] tbl_yel   [TABLE_DEPTH];
	logic [15:0] tbl_red   [TABLE_DEPTH];
	logic [15:0] tbl_walk  [TABLE_DEPTH];
	logic [15:0] tbl_flash [TABLE_DEPTH];

	out_item_t pending_states[$];
	int        fails;
	int        cycles;
	bit        quiet;   // no idling on either side while set

	// Length of one phase, all four vehicle intervals
	function automatic longint phase_len(int i);
		return longint'(tbl_lead[i]) + longint'(tbl_green[i]) + longint'(tbl_yel[i])
			+ longint'(tbl_red[i]);
	endfunction

	// Signal state for one item; a load updates the table and answers all zeros
	function automatic out_item_t signal_state(in_item_t it);
		out_item_t r;
		longint    limit, walk, flash, total, cyc, rel, tc, start, loc;
		longint    lead, green, yel, gs, ge, d, wait_best, green_rem, go;
		int        n;
		logic [1:0] veh, ped, v, p;
		bit        found, in_green;
		r = '0;
		if (it.operation == OP_LOAD) begin
			limit = longint'(it.lead_interval) + longint'(it.green_time)
				+ longint'(it.yellow_time);
			walk = longint'(it.walk_time);
			flash = longint'(it.flash_time);
			// pedestrian intervals must be over by the end of yellow
			if (walk + flash > limit) begin
				if (flash > limit)
					flash = limit;
				walk = limit - flash;
			end
			tbl_group[it.phase_slot] = it.group_id;
			tbl_lead[it.phase_slot]  = it.lead_interval;
			tbl_green[it.phase_slot] = it.green_time;
			tbl_yel[it.phase_slot]   = it.yellow_time;
			tbl_red[it.phase_slot]   = it.all_red_time;
			tbl_walk[it.phase_slot]  = walk[15:0];
			tbl_flash[it.phase_slot] = flash[15:0];
			return r;
		end
		n = (plan_phases > TABLE_DEPTH) ? TABLE_DEPTH : int'(plan_phases);
		total = 0;
		for (int i = 0; i < n; i++)
			total += phase_len(i);
		cyc = (total > 0) ? total : longint'(MIN_CYCLE);
		if (longint'(plan_cycle_decl) > cyc)
			cyc = longint'(plan_cycle_decl);
		// time before the offset wraps up into the cycle
		rel = longint'(it.query_time) - longint'(plan_ofs);
		tc = rel % cyc;
		if (tc < 0)
			tc += cyc;
		start = 0;
		wait_best = -1;
		green_rem = 0;
		go = 0;
		veh = VEH_OFF;
		ped = PED_OFF;
		found = 1'b0;
		in_green = 1'b0;
		for (int i = 0; i < n; i++) begin
			if (tbl_group[i] == it.group_id) begin
				lead = longint'(tbl_lead[i]);
				green = longint'(tbl_green[i]);
				yel = longint'(tbl_yel[i]);
				loc = tc - start;
				gs = start + lead;
				ge = gs + green;
				found = 1'b1;
				v = VEH_RED;
				p = PED_DONT;
				if (loc >= lead && loc < lead + green)
					v = VEH_GRN;
				else if (loc >= lead + green && loc < lead + green + yel)
					v = VEH_YEL;
				if (v > veh)
					veh = v;
				if (loc >= 0 && loc < longint'(tbl_walk[i]))
					p = PED_WALK;
				else if (loc >= longint'(tbl_walk[i])
						&& loc < longint'(tbl_walk[i]) + longint'(tbl_flash[i]))
					p = PED_FLASH;
				if (p > ped)
					ped = p;
				// first green of the group that covers the time sets the remainder
				if (tc >= gs && tc < ge) begin
					if (!in_green)
						green_rem = ge - tc;
					in_green = 1'b1;
				end
				d = gs - tc;
				if (d < 0)
					d += cyc;
				if (wait_best < 0 || d < wait_best)
					wait_best = d;
				go += green + yel;
			end
			start += phase_len(i);
		end
		if (!found)
			return r;
		r.vehicle_aspect = veh;
		r.pedestrian_aspect = ped;
		r.wait_to_green = in_green ? '0 : wait_best[23:0];
		r.green_left = in_green ? green_rem[23:0] : '0;
		r.red_time = (cyc > go) ? 24'(cyc - go) : '0;
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Interval value: extremes now and then, otherwise small so plans stay short
	function automatic logic [15:0] ticks16(int hi);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return 16'hFFFF;
		if (r < 8)
			return 16'($urandom);
		return 16'($urandom_range(0, hi));
	endfunction

	function automatic logic [7:0] pick_group();
		return ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
	endfunction

	function automatic in_item_t phase_item(logic [4:0] slot);
		in_item_t it;
		it = '0;
		it.query_time = $urandom;   // not used by a load
		it.operation = OP_LOAD;
		it.phase_slot = slot;
		it.group_id = pick_group();
		it.lead_interval = ticks16(6);
		it.green_time = ticks16(40);
		it.yellow_time = ticks16(8);
		it.all_red_time = ticks16(6);
		it.walk_time = ticks16(50);
		it.flash_time = ticks16(30);
		return it;
	endfunction

	function automatic in_item_t query_item();
		in_item_t it;
		int r;
		it.lead_interval = 16'($urandom);
		it.green_time = 16'($urandom);
		it.yellow_time = 16'($urandom);
		it.all_red_time = 16'($urandom);
		it.walk_time = 16'($urandom);
		it.flash_time = 16'($urandom);
		it.phase_slot = 5'($urandom);
		it.operation = OP_QUERY;
		it.group_id = pick_group();
		r = $urandom_range(0, 9);
		if (r < 4)
			it.query_time = $urandom;
		else if (r < 6)
			it.query_time = $urandom_range(0, 400);             // often below the offset
		else if (r < 7)
			it.query_time = 32'hFFFF_FFFF - $urandom_range(0, 400);
		else
			it.query_time = 32'(plan_ofs) + $urandom_range(0, 600);
		return it;
	endfunction

	// Present one item and hold it until taken; the expectation is booked at acceptance.
	// Valid stays high into the next item when there is no gap.
	task automatic send_item(in_item_t it, bit typed, out_item_t want);
		out_item_t pred;
		int        gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (in_stall);
		pred = signal_state(it);
		pending_states.insert(pending_states.size(), typed ? want : pred);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_states.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_OFFSET: plan_ofs = val[15:0];
			REG_CYCLE:  plan_cycle_decl = val;
			REG_COUNT:  plan_phases = val[5:0];
			default: ;
		endcase
	endtask

	// Directed rows: extremes, pedestrian clipping, both operations
	typedef struct {
		in_item_t  it;
		bit        typed;
		out_item_t want;
	} drow_t;

	function automatic in_item_t mk(logic op, logic [4:0] slot, logic [7:0] grp,
			logic [15:0] ld, logic [15:0] gr, logic [15:0] ye, logic [15:0] ar,
			logic [15:0] wk, logic [15:0] fl, logic [31:0] qt);
		in_item_t it;
		it.operation = op;
		it.phase_slot = slot;
		it.group_id = grp;
		it.lead_interval = ld;
		it.green_time = gr;
		it.yellow_time = ye;
		it.all_red_time = ar;
		it.walk_time = wk;
		it.flash_time = fl;
		it.query_time = qt;
		return it;
	endfunction

	drow_t directed[$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: random stalls, in bursts
	int stall_hold;
	always @(negedge clk) begin
		if (stall_hold > 0) begin
			stall_hold--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			stall_hold = gap_len();
		end
	end

	// Scoreboard: every accepted result against the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_states.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result %p", out_item);
			end else begin
				want = pending_states.pop_front();
				if (out_item.vehicle_aspect !== want.vehicle_aspect
						|| out_item.pedestrian_aspect !== want.pedestrian_aspect
						|| out_item.wait_to_green !== want.wait_to_green
						|| out_item.green_left !== want.green_left
						|| out_item.red_time !== want.red_time) begin
					fails++;
					if (fails <= 10)
						$display("mismatch: expected %p, got %p", want, out_item);
				end
			end
		end
	end

	initial begin
		out_item_t zero;
		int        pick;
		zero = '0;
		fails = 0;
		cycles = 0;
		quiet = 0;
		stall_hold = 0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_OFFSET;
		cfg_data = '0;
		plan_ofs = '0;
		plan_cycle_decl = '0;
		plan_phases = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// After reset no phase is in use: every query answers all zeros (group absent).
		// Loads answer zeros too.
		directed.insert(directed.size(), '{mk(OP_QUERY, 0, 8'h00, 0, 0, 0, 0, 0, 0, 0),
			1, zero});
		directed.insert(directed.size(), '{mk(OP_QUERY, 31, 8'hFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), 1, zero});
		directed.insert(directed.size(), '{mk(OP_LOAD, 0, 8'h00, 0, 0, 0, 0, 0, 0, 0),
			1, zero});
		directed.insert(directed.size(), '{mk(OP_LOAD, 31, 8'hFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), 1, zero});
		// walk plus flash past the end of yellow: walk cut back
		directed.insert(directed.size(), '{mk(OP_LOAD, 1, 8'h01, 2, 10, 3, 2, 12, 4, 0),
			1, zero});
		// flash alone past the end of yellow: flash cut, no walk left
		directed.insert(directed.size(), '{mk(OP_LOAD, 2, 8'h02, 1, 5, 2, 1, 7, 20, 0),
			1, zero});
		directed.insert(directed.size(), '{mk(OP_LOAD, 3, 8'h01, 0, 20, 4, 0, 6, 6, 0),
			1, zero});
		directed.insert(directed.size(), '{mk(OP_LOAD, 4, 8'h00, 16'hFFFF, 0, 0, 16'hFFFF,
			16'hFFFF, 0, 0), 1, zero});
		directed.insert(directed.size(), '{mk(OP_QUERY, 5, 8'h01, 0, 0, 0, 0, 0, 0,
			32'h8000_0000), 1, zero});
		foreach (directed[k])
			send_item(directed[k].it, directed[k].typed, directed[k].want);

		// Fill the whole table so every phase count is safe to query
		for (int s = 0; s < TABLE_DEPTH; s++)
			send_item(phase_item(5'(s)), 0, zero);

		// Plans: extremes first, then random settings
		for (int ph = 0; ph < 10; ph++) begin
			drain();
			case (ph)
				0: begin
					write_reg(REG_OFFSET, 24'd0);
					write_reg(REG_CYCLE, 24'd0);
					write_reg(REG_COUNT, 24'd1);
				end
				1: begin
					write_reg(REG_OFFSET, 24'hFFFF);
					write_reg(REG_CYCLE, 24'hFF_FFFF);
					write_reg(REG_COUNT, 24'd32);
				end
				2: begin
					// count beyond the table reads as the full table
					write_reg(REG_OFFSET, 24'($urandom_range(0, 300)));
					write_reg(REG_CYCLE, 24'd0);
					write_reg(REG_COUNT, 24'd63);
				end
				3: begin
					write_reg(REG_COUNT, 24'd0);
					write_reg(REG_CYCLE, 24'($urandom_range(0, 60)));
				end
				default: begin
					write_reg(REG_OFFSET, ($urandom_range(0, 3) == 0) ? 24'($urandom)
						: 24'($urandom_range(0, 500)));
					write_reg(REG_CYCLE, ($urandom_range(0, 3) == 0) ? 24'($urandom)
						: 24'($urandom_range(0, 400)));
					write_reg(REG_COUNT, 24'($urandom_range(1, 63)));
				end
			endcase
			quiet = (ph % 3 == 2);
			for (int k = 0; k < 42; k++) begin
				pick = $urandom_range(0, 9);
				if (pick < 3)
					send_item(phase_item(5'($urandom)), 0, zero);
				else
					send_item(query_item(), 0, zero);
			end
			quiet = 0;
		end

		// End of stimulus: wait for the last results, then let the clock run on before the verdict
		in_valid <= 1'b0;
		while (pending_states.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (fails == 0 && pending_states.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hdl
hdl/ftsq_pkg.sv
hdl/ftsq_ctrl.sv
hdl/ftsq_datapath.sv
hdl/fixed_time_signal_state_query_unit.sv
hdl/ftsq_checker.sv
dv/fixed_time_signal_state_query_unit_tb.sv
